// File: rtl/core/ndef_tlv_stream_reader_core_macros.svh
// Assertion macros shared by the NDEF TLV stream reader RTL.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef NDEF_TLV_STREAM_READER_CORE_MACROS_SVH
`define NDEF_TLV_STREAM_READER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NTSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define NTSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ntsr_pkg.sv
// Package for the NDEF TLV stream reader: parser phases, result kinds, constants
// and the result struct. No dependencies.
package ntsr_pkg;

  // Parser phase, one per position in the capability container and TLV walk.
  typedef enum logic [3:0] {
    PH_CC0     = 4'd0,
    PH_CC1     = 4'd1,
    PH_CC2     = 4'd2,
    PH_CC3     = 4'd3,
    PH_CC4     = 4'd4,
    PH_CC5     = 4'd5,
    PH_CC6     = 4'd6,
    PH_CC7     = 4'd7,
    PH_TAG     = 4'd8,
    PH_LEN0    = 4'd9,
    PH_LENHI   = 4'd10,
    PH_LENLO   = 4'd11,
    PH_SKIP    = 4'd12,
    PH_PAYLOAD = 4'd13,
    PH_DRAIN   = 4'd14
  } phase_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_DONE      = 3'd1,
    KIND_BAD_MAGIC = 3'd2,
    KIND_OVERFLOW  = 3'd3,
    KIND_EARLY_END = 3'd4
  } kind_t;

  localparam logic [7:0]  CC_MAGIC_V1  = 8'hE1;
  localparam logic [7:0]  CC_MAGIC_V2  = 8'hE2;
  localparam logic [7:0]  TLV_NULL     = 8'h00;
  localparam logic [7:0]  TLV_NDEF     = 8'h03;
  localparam logic [7:0]  TLV_TERM     = 8'hFE;
  localparam logic [7:0]  TLV_LEN_ESC  = 8'hFF;
  localparam logic [19:0] AREA_DEFAULT = 20'd256;
  localparam logic [19:0] CC_SHORT_LEN = 20'd4;
  localparam logic [19:0] CC_LONG_LEN  = 20'd8;

  // One result item.
  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] message_length;
    logic        last;
  } res_t;

endpackage

// File: rtl/core/ntsr_parse.sv
// Parser state and per-byte result logic for the NDEF TLV stream reader.
// Depends on ntsr_pkg.
module ntsr_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         mem_byte,
  input  logic               mem_end,
  input  logic [15:0]        buffer_capacity,
  output ntsr_pkg::res_t     res
);
  import ntsr_pkg::*;

  phase_t      phase, phase_next;
  logic [19:0] offset, offset_next;
  logic [19:0] area_limit, area_limit_next;
  logic [7:0]  size_high_byte, size_high_byte_next;
  logic [7:0]  tlv_kind, tlv_kind_next;
  logic [15:0] tlv_length, tlv_length_next;
  logic [15:0] bytes_left, bytes_left_next;

  logic [19:0] off_inc;
  logic [15:0] len_val;
  logic        len_phase;
  logic        is_ndef;
  logic        skip_end;
  logic        magic_ok;
  logic [15:0] cc_units;
  logic [19:0] long_area;
  logic [15:0] bytes_dec;
  logic        emit;
  logic        emit_fin;
  kind_t       emit_kind;
  logic [7:0]  emit_data;
  logic [15:0] emit_len;

  // Shared decode of the current byte.
  assign off_inc   = offset + 20'd1;
  assign len_phase = ((phase == PH_LEN0) && (mem_byte != TLV_LEN_ESC)) || (phase == PH_LENLO);
  assign len_val   = (phase == PH_LENLO) ? {size_high_byte, mem_byte} : {8'd0, mem_byte};
  assign is_ndef   = (tlv_kind == TLV_NDEF);
  assign skip_end  = ({1'b0, off_inc} + {5'd0, len_val}) >= {1'b0, area_limit};
  assign magic_ok  = (tlv_kind == CC_MAGIC_V1) || (tlv_kind == CC_MAGIC_V2);
  assign cc_units  = {size_high_byte, mem_byte};
  assign long_area = (cc_units == 16'd0) ? AREA_DEFAULT : {1'b0, cc_units, 3'b000};
  assign bytes_dec = bytes_left - 16'd1;

  // Result of the byte before the end-of-memory override.
  always_comb begin
    emit      = 1'b0;
    emit_fin  = 1'b0;
    emit_kind = KIND_DONE;
    emit_data = 8'd0;
    emit_len  = 16'd0;
    if (phase == PH_CC3) begin
      if (!magic_ok) begin
        emit      = 1'b1;
        emit_fin  = 1'b1;
        emit_kind = KIND_BAD_MAGIC;
      end
    end else if (phase == PH_TAG) begin
      if ((mem_byte == TLV_TERM) || (off_inc >= area_limit)) begin
        emit     = 1'b1;
        emit_fin = 1'b1;
      end
    end else if (len_phase) begin
      if (is_ndef) begin
        if (len_val > buffer_capacity) begin
          emit      = 1'b1;
          emit_fin  = 1'b1;
          emit_kind = KIND_OVERFLOW;
          emit_len  = len_val;
        end else if (len_val == 16'd0) begin
          emit     = 1'b1;
          emit_fin = 1'b1;
        end
      end else if (skip_end) begin
        emit     = 1'b1;
        emit_fin = 1'b1;
      end
    end else if (phase == PH_PAYLOAD) begin
      emit      = 1'b1;
      emit_fin  = (bytes_dec == 16'd0);
      emit_kind = KIND_PAYLOAD;
      emit_data = mem_byte;
      emit_len  = tlv_length;
    end
  end

  // Final result: memory ending before the parse is finished overrides.
  always_comb begin
    res.valid          = emit;
    res.kind           = emit_kind;
    res.data_byte      = emit_data;
    res.message_length = emit_len;
    res.last           = emit_fin;
    if (mem_end && (phase != PH_DRAIN) && !emit_fin) begin
      res.valid          = 1'b1;
      res.kind           = KIND_EARLY_END;
      res.data_byte      = 8'd0;
      res.message_length = 16'd0;
      res.last           = 1'b1;
    end
  end

  // Next parser state.
  always_comb begin
    phase_next          = phase;
    offset_next         = offset;
    area_limit_next     = area_limit;
    size_high_byte_next = size_high_byte;
    tlv_kind_next       = tlv_kind;
    tlv_length_next     = tlv_length;
    bytes_left_next     = bytes_left;
    unique case (phase)
      PH_CC0: begin
        tlv_kind_next = mem_byte;
        phase_next    = PH_CC1;
      end
      PH_CC1: phase_next = PH_CC2;
      PH_CC2: begin
        size_high_byte_next = mem_byte;
        phase_next          = PH_CC3;
      end
      PH_CC3: begin
        if (magic_ok) begin
          if ((tlv_kind == CC_MAGIC_V2) || (size_high_byte == 8'd0)) begin
            phase_next = PH_CC4;
          end else begin
            area_limit_next = CC_SHORT_LEN + {9'd0, size_high_byte, 3'b000};
            offset_next     = CC_SHORT_LEN;
            phase_next      = PH_TAG;
          end
        end
      end
      PH_CC4: phase_next = PH_CC5;
      PH_CC5: phase_next = PH_CC6;
      PH_CC6: begin
        size_high_byte_next = mem_byte;
        phase_next          = PH_CC7;
      end
      PH_CC7: begin
        area_limit_next = CC_LONG_LEN + long_area;
        offset_next     = CC_LONG_LEN;
        phase_next      = PH_TAG;
      end
      PH_TAG: begin
        offset_next = off_inc;
        if (mem_byte != TLV_NULL) begin
          tlv_kind_next = mem_byte;
          phase_next    = PH_LEN0;
        end
      end
      PH_LEN0, PH_LENLO: begin
        offset_next = off_inc;
        if (!len_phase) begin
          phase_next = PH_LENHI;
        end else begin
          tlv_length_next = len_val;
          if (is_ndef) begin
            bytes_left_next = len_val;
            phase_next      = PH_PAYLOAD;
          end else if (len_val == 16'd0) begin
            phase_next = PH_TAG;
          end else begin
            bytes_left_next = len_val;
            phase_next      = PH_SKIP;
          end
        end
      end
      PH_LENHI: begin
        offset_next         = off_inc;
        size_high_byte_next = mem_byte;
        phase_next          = PH_LENLO;
      end
      PH_SKIP: begin
        offset_next     = off_inc;
        bytes_left_next = bytes_dec;
        if (bytes_dec == 16'd0) begin
          phase_next = PH_TAG;
        end
      end
      PH_PAYLOAD: bytes_left_next = bytes_dec;
      default: ;
    endcase
    // The end of memory restarts the parse; a finished parse drains.
    if (mem_end) begin
      phase_next          = PH_CC0;
      offset_next         = 20'd0;
      area_limit_next     = 20'd0;
      size_high_byte_next = 8'd0;
      tlv_kind_next       = 8'd0;
      tlv_length_next     = 16'd0;
      bytes_left_next     = 16'd0;
    end else if (emit_fin) begin
      phase_next = PH_DRAIN;
    end
  end

  // State registers, advanced once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CC0;
      offset         <= 20'd0;
      area_limit     <= 20'd0;
      size_high_byte <= 8'd0;
      tlv_kind       <= 8'd0;
      tlv_length     <= 16'd0;
      bytes_left     <= 16'd0;
    end else if (step) begin
      phase          <= phase_next;
      offset         <= offset_next;
      area_limit     <= area_limit_next;
      size_high_byte <= size_high_byte_next;
      tlv_kind       <= tlv_kind_next;
      tlv_length     <= tlv_length_next;
      bytes_left     <= bytes_left_next;
    end
  end

endmodule

// File: rtl/core/ndef_tlv_stream_reader_core.sv
// NDEF TLV stream reader: usage summary.
// Input beats on s_axis carry one tag memory byte each, in ascending offset
// order from zero; tlast marks the last available byte, after which the
// parser starts over with a new capability container.
// The parser checks the capability container, walks the TLVs and, for the
// first NDEF TLV, emits each payload byte on m_axis (tuser kind 0). Other
// results are done without message, bad magic, overflow and memory ended
// early; tlast flags the final result of a parse. Bytes after a final result
// give nothing until the next tlast byte.
// Configuration: a beat on cfg sets buffer_capacity (reset 65535); write it
// only while the block is idle. cfg_ready is always high.
// Results are registered in the output buffer before they appear on m_axis.
// Throughput: one byte per cycle while s_axis_tready is high; the state update
// is a single pass over a 20-bit increment feeding a 21-bit add and compare. A
// two-entry output buffer lets input continue while one result waits; s_axis_tready
// drops only when both entries are full.
// Reset (rst, synchronous) empties the buffer and returns the parser to
// capability container byte zero.
// Depends on ntsr_pkg, ntsr_parse and ndef_tlv_stream_reader_core_macros.svh.
`include "ndef_tlv_stream_reader_core_macros.svh"

module ndef_tlv_stream_reader_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] mem_byte
  input  logic        s_axis_tlast,   // mem_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] message_length
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data        // [15:0] buffer_capacity
);
  import ntsr_pkg::*;

  logic [15:0] buffer_capacity;
  logic        step;
  res_t        res;
  res_t        buf_entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  buf_count;
  logic        push;
  logic        pop;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_capacity <= 16'hFFFF;
    end else if (cfg_valid) begin
      buffer_capacity <= cfg_data;
    end
  end

  // Input handshake: accept whenever an output entry is free.
  assign s_axis_tready = (buf_count != 2'd2);
  assign step          = s_axis_tvalid && s_axis_tready;

  ntsr_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .mem_byte        (s_axis_tdata),
    .mem_end         (s_axis_tlast),
    .buffer_capacity (buffer_capacity),
    .res             (res)
  );

  // Two-entry result buffer.
  assign push = step && res.valid;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_entry[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      buf_count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   buf_count <= buf_count + 2'd1;
        2'b01:   buf_count <= buf_count - 2'd1;
        default: buf_count <= buf_count;
      endcase
    end
  end

  // Output beat from the oldest entry.
  assign m_axis_tvalid = (buf_count != 2'd0);
  assign m_axis_tdata  = {buf_entry[rd_ptr].message_length, buf_entry[rd_ptr].data_byte};
  assign m_axis_tuser  = buf_entry[rd_ptr].kind;
  assign m_axis_tlast  = buf_entry[rd_ptr].last;

  // Checks on the buffer and the parser results.
  `NTSR_ASSERT_NOW(a_count_range, 1'b1, buf_count != 2'd3, "result buffer count out of range")
  `NTSR_ASSERT_NEXT(a_count_grows, push && !pop, buf_count == $past(buf_count) + 2'd1, "result buffer count did not grow on a lone write")
  `NTSR_ASSERT_NOW(a_payload_len, push && (res.kind == KIND_PAYLOAD), res.message_length != 16'd0, "payload result with zero message length")

endmodule

// File: verif/ndef_tlv_stream_reader_core_test.sv
// Self-checking testbench for ndef_tlv_stream_reader_core: feeds tag memory images,
// predicts every result with a scoreboard of its own and compares each output beat.
// Depends on ntsr_pkg and the ndef_tlv_stream_reader_core RTL.
`timescale 1ns / 100ps

module ndef_tlv_stream_reader_core_test;
  import ntsr_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASES         = 6;
  localparam int BYTES_PER_PHASE = 260;
  localparam int MAX_REPORTS    = 10;

  // One expected or observed result beat.
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [15:0] msg_len;
    logic        last;
  } tag_result_t;

  // Tracks the parser state and holds the results it still owes.
  class tag_parse_scoreboard;
    phase_t      ph;
    bit [19:0]   offs;
    bit [19:0]   limit;
    bit [7:0]    hold;
    bit [7:0]    tag;
    bit [15:0]   tlen;
    bit [15:0]   left;
    bit [15:0]   capacity;
    tag_result_t expected_results[$];
    tag_result_t res;
    bit          has_res;
    int          errors;
    int          parsed_bytes;

    function new();
      capacity = 16'hFFFF;
      errors = 0;
      parsed_bytes = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      ph = PH_CC0;
      offs = '0;
      limit = '0;
      hold = '0;
      tag = '0;
      tlen = '0;
      left = '0;
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void emit(kind_t k, bit [7:0] d, bit [15:0] l, bit fin);
      res = '{k, d, l, fin};
      has_res = 1'b1;
    endfunction

    function void set_area(bit [19:0] cc_len, bit [15:0] units);
      bit [19:0] area;
      area = {1'b0, units, 3'b000};
      limit = cc_len + ((area != '0) ? area : AREA_DEFAULT);
      offs = cc_len;
      ph = PH_TAG;
    endfunction

    // The TLV length is complete: start the payload, skip the TLV or stop.
    function void length_known(bit [15:0] len);
      tlen = len;
      if (tag == TLV_NDEF) begin
        if (tlen > capacity) begin
          emit(KIND_OVERFLOW, 8'h00, tlen, 1'b1);
        end else if (tlen == '0) begin
          emit(KIND_DONE, 8'h00, 16'h0000, 1'b1);
        end else begin
          left = tlen;
          ph = PH_PAYLOAD;
        end
      end else if (32'(offs) + 32'(tlen) >= 32'(limit)) begin
        emit(KIND_DONE, 8'h00, 16'h0000, 1'b1);
      end else if (tlen == '0) begin
        ph = PH_TAG;
      end else begin
        left = tlen;
        ph = PH_SKIP;
      end
    endfunction

    // Called for every accepted input beat.
    function void note_byte(bit [7:0] b, bit mem_end);
      bit draining;
      draining = (ph == PH_DRAIN);
      has_res = 1'b0;
      parsed_bytes++;
      case (ph)
        PH_CC0: begin
          tag = b;
          ph = PH_CC1;
        end
        PH_CC1: ph = PH_CC2;
        PH_CC2: begin
          hold = b;
          ph = PH_CC3;
        end
        PH_CC3: begin
          if (tag != CC_MAGIC_V1 && tag != CC_MAGIC_V2) begin
            emit(KIND_BAD_MAGIC, 8'h00, 16'h0000, 1'b1);
          end else if (tag == CC_MAGIC_V2 || hold == 8'h00) begin
            ph = PH_CC4;
          end else begin
            set_area(CC_SHORT_LEN, {8'h00, hold});
          end
        end
        PH_CC4: ph = PH_CC5;
        PH_CC5: ph = PH_CC6;
        PH_CC6: begin
          hold = b;
          ph = PH_CC7;
        end
        PH_CC7: set_area(CC_LONG_LEN, {hold, b});
        PH_TAG: begin
          offs = offs + 20'd1;
          if (b == TLV_TERM || offs >= limit) begin
            emit(KIND_DONE, 8'h00, 16'h0000, 1'b1);
          end else if (b != TLV_NULL) begin
            tag = b;
            ph = PH_LEN0;
          end
        end
        PH_LEN0: begin
          offs = offs + 20'd1;
          if (b == TLV_LEN_ESC) ph = PH_LENHI;
          else length_known({8'h00, b});
        end
        PH_LENHI: begin
          offs = offs + 20'd1;
          hold = b;
          ph = PH_LENLO;
        end
        PH_LENLO: begin
          offs = offs + 20'd1;
          length_known({hold, b});
        end
        PH_SKIP: begin
          offs = offs + 20'd1;
          left = left - 16'd1;
          if (left == '0) ph = PH_TAG;
        end
        PH_PAYLOAD: begin
          left = left - 16'd1;
          emit(KIND_PAYLOAD, b, tlen, left == '0);
        end
        default: ;
      endcase

      // A final result always carries last, so it tells whether the parse ended here.
      if (mem_end) begin
        if (!draining && !(has_res && res.last)) emit(KIND_EARLY_END, 8'h00, 16'h0000, 1'b1);
        clear_parse();
      end else if (has_res && res.last) begin
        ph = PH_DRAIN;
      end
      if (has_res) expected_results.push_back(res);
    endfunction

    // Called for every accepted output beat.
    function void check_result(tag_result_t got);
      tag_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected result kind %0d data %h len %0d last %b",
                   got.kind, got.data_byte, got.msg_len, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.msg_len !== want.msg_len || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("ERROR: result mismatch: expected kind %0d data %h len %0d last %b",
                   want.kind, want.data_byte, want.msg_len, want.last);
          $display("       got kind %0d data %h len %0d last %b",
                   got.kind, got.data_byte, got.msg_len, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  tag_parse_scoreboard sb = new();
  bit        tx_calm = 1'b0;
  bit        rx_calm = 1'b0;
  int        idle_cycles = 0;
  bit [7:0]  tag_img[$];
  bit [15:0] cap_plan[PHASES] = '{16'hFFFF, 16'h0000, 16'd12, 16'd0, 16'hFFFF, 16'd300};

  ndef_tlv_stream_reader_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver back-pressure, off during the calm stretch.
  always @(posedge clk) begin
    m_axis_tready <= rx_calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  // Beat monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result('{kind_t'(m_axis_tuser), m_axis_tdata[7:0], m_axis_tdata[23:8],
                          m_axis_tlast});
      if (cfg_valid && cfg_ready) sb.capacity = cfg_data;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("ndef_tlv_stream_reader_core_test failed");
          $finish;
        end
      end
    end
  end

  // Sends one memory byte, with a random gap in front unless the stretch is calm.
  task automatic send_byte(input bit [7:0] b, input bit mem_end);
    while (!tx_calm && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= mem_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Sends the current image, flagging its final byte.
  task automatic send_tag();
    foreach (tag_img[i]) send_byte(tag_img[i], i == tag_img.size() - 1);
  endtask

  // Stops sending until every owed result has arrived and the block has settled.
  // The first edge lets the monitor note the last accepted byte.
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input bit [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Appends a TLV length in the one-byte or the escaped three-byte form.
  task automatic push_length(input int len);
    if (len > 254 || $urandom_range(0, 3) == 0) begin
      tag_img.push_back(TLV_LEN_ESC);
      tag_img.push_back(8'(len >> 8));
      tag_img.push_back(8'(len));
    end else begin
      tag_img.push_back(8'(len));
    end
  endtask

  // Builds a random tag image: mostly a sound container and TLV walk with random
  // content, sometimes cut short, sometimes plain noise.
  task automatic make_tag(input bit [15:0] cap);
    int       n;
    int       len;
    bit [7:0] magic;
    bit [7:0] size_byte;
    bit [7:0] t;
    tag_img.delete();
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 12);
      repeat (n) tag_img.push_back(8'($urandom));
      return;
    end

    // Capability container; a zero size byte or the V2 magic selects the long form.
    case ($urandom_range(0, 9))
      0:       magic = 8'($urandom);
      1, 2, 3: magic = CC_MAGIC_V2;
      default: magic = CC_MAGIC_V1;
    endcase
    tag_img.push_back(magic);
    tag_img.push_back(8'($urandom));
    if ($urandom_range(0, 3) == 0) size_byte = 8'h00;
    else if ($urandom_range(0, 1) == 0) size_byte = 8'($urandom_range(1, 6));
    else size_byte = 8'($urandom);
    tag_img.push_back(size_byte);
    tag_img.push_back(8'($urandom));
    if (magic == CC_MAGIC_V2 || size_byte == 8'h00) begin
      tag_img.push_back(8'($urandom));
      tag_img.push_back(8'($urandom));
      tag_img.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
      tag_img.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
    end

    // Null TLVs and foreign TLVs ahead of the message.
    n = $urandom_range(0, 3);
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) begin
        tag_img.push_back(TLV_NULL);
      end else begin
        t = 8'($urandom_range(1, 255));
        if (t == TLV_NDEF || t == TLV_TERM) t = 8'h01;
        tag_img.push_back(t);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 300) : $urandom_range(0, 5);
        push_length(len);
        repeat ((len > 40) ? 40 : len) tag_img.push_back(8'($urandom));
      end
    end

    // The message itself, a terminator, or neither.
    n = $urandom_range(0, 99);
    if (n < 70) begin
      tag_img.push_back(TLV_NDEF);
      if (cap != 16'hFFFF && $urandom_range(0, 9) == 0) len = $urandom_range(cap + 1, 65535);
      else len = $urandom_range(0, 24);
      push_length(len);
      if (len <= cap) repeat (len) tag_img.push_back(8'($urandom));
    end else if (n < 90) begin
      tag_img.push_back(TLV_TERM);
    end
    repeat ($urandom_range(0, 3)) tag_img.push_back(8'($urandom));

    // Memory that ends early.
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, tag_img.size());
      while (tag_img.size() > n) void'(tag_img.pop_back());
    end
  endtask

  // Stimulus: directed tags, then random tags across several capacity settings.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        if (p == 3) cap_plan[p] = 16'($urandom_range(1, 30));
        write_capacity(cap_plan[p]);
      end
      tx_calm = (p == 2);
      rx_calm <= (p == 2);

      if (p == 0) begin
        // Short container: null TLV, skipped TLV, then a three-byte message
        // whose last payload byte also ends memory.
        tag_img = '{8'hE1, 8'h10, 8'h01, 8'h00, TLV_NULL, 8'h01, 8'h01, 8'h7F,
                    TLV_NDEF, 8'h03, 8'h00, 8'hFF, 8'h80};
        send_tag();
        // Bad magic.
        tag_img = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_tag();
        // Long container with default area size and an empty message in long form.
        tag_img = '{CC_MAGIC_V2, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    TLV_NDEF, TLV_LEN_ESC, 8'h00, 8'h00};
        send_tag();
      end

      while (sb.parsed_bytes < (p + 1) * BYTES_PER_PHASE) begin
        make_tag(sb.capacity);
        send_tag();
        if ($urandom_range(0, 19) == 0) drain_wait();
      end
      drain_wait();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ndef_tlv_stream_reader_core_test passed");
    end else begin
      $display("ndef_tlv_stream_reader_core_test failed");
    end
    $finish;
  end

endmodule
